// ===== rtl/directory_coherence_controller_macros.svh =====
// Assertion macros for the directory coherence controller.
// Used by the controller and the top level; no dependencies.
`ifndef DIRECTORY_COHERENCE_CONTROLLER_MACROS_SVH
`define DIRECTORY_COHERENCE_CONTROLLER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DCC_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define DCC_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error(msg);

`endif

// ===== rtl/dcc_pkg.sv =====
// Package for the directory coherence controller: sizes, codes, payload types
// and the command and status structs between controller and datapath.
`default_nettype none
package dcc_pkg;
  localparam int unsigned NODES = 16;
  localparam int unsigned BLOCKS = 1024;
  localparam int unsigned NODE_W = 4;
  localparam int unsigned BLK_W = 10;
  localparam int unsigned CNT_W = 5;

  localparam logic [2:0] ST_UN = 3'd0;
  localparam logic [2:0] ST_SH = 3'd1;
  localparam logic [2:0] ST_DI = 3'd2;
  localparam logic [2:0] ST_TOSH = 3'd3;
  localparam logic [2:0] ST_TODI = 3'd4;

  localparam logic [3:0] MT_RD_MISS = 4'd0;
  localparam logic [3:0] MT_WR_MISS = 4'd1;
  localparam logic [3:0] MT_WR_SHARED = 4'd2;
  localparam logic [3:0] MT_EVICT_SH = 4'd3;
  localparam logic [3:0] MT_EVICT_DI = 4'd4;
  localparam logic [3:0] MT_ACK_RMD = 4'd5;
  localparam logic [3:0] MT_ACK_WMD = 4'd6;
  localparam logic [3:0] MT_ACK_WMS = 4'd7;
  localparam logic [3:0] MT_ACK_WSN = 4'd8;

  localparam logic [3:0] RP_RD_ACK = 4'd0;
  localparam logic [3:0] RP_WR_ACK = 4'd1;
  localparam logic [3:0] RP_WR_SHDATA = 4'd2;
  localparam logic [3:0] RP_WS_ONLY = 4'd3;
  localparam logic [3:0] RP_EV_SH = 4'd4;
  localparam logic [3:0] RP_EV_DI = 4'd5;
  localparam logic [3:0] RP_WMS_AGG = 4'd6;
  localparam logic [3:0] RP_WSN_AGG = 4'd7;
  localparam logic [3:0] RP_AG_RMD = 4'd8;
  localparam logic [3:0] RP_AG_WMD = 4'd9;
  localparam logic [3:0] RP_AG_WMS = 4'd10;
  localparam logic [3:0] RP_AG_WSN = 4'd11;
  localparam logic [3:0] RP_BM_FAIL = 4'd12;
  localparam logic [3:0] RP_ST_FAIL = 4'd13;

  typedef struct packed {
    logic        kind;
    logic [3:0]  msg_type;
    logic [9:0]  block_index;
    logic [31:0] block_address;
    logic [3:0]  requester_node;
    logic [31:0] requester_line_address;
    logic [3:0]  agent_node;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  reply_type;
    logic [3:0]  dest_node;
    logic [3:0]  owner_node;
    logic [31:0] owner_line_address;
    logic [31:0] out_block_address;
    logic [3:0]  out_requester_node;
    logic [31:0] out_requester_address;
    logic [15:0] sharers;
    logic        last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic              rd_entry;   // read entry fields of the block
    logic              wr_entry;   // write decided entry fields
    logic              wr_line;    // write requester line address
    logic              rd_line;    // read line address of rd_node
    logic [NODE_W-1:0] rd_node;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0]        st;
    logic [CNT_W-1:0]  cnt;
    logic [NODES-1:0]  bm;
    logic [31:0]       baddr;
    logic [31:0]       laddr;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/dcc_datapath.sv =====
// Directory datapath: entry memory and node line address memory.
// Depends on dcc_pkg.
`default_nettype none
module dcc_datapath (
  input  wire logic                 clk_i,
  input  wire dcc_pkg::dp_cmd_t     cmd_i,
  input  wire logic [9:0]           blk_i,
  input  wire logic [31:0]          baddr_i,
  input  wire logic [3:0]           req_i,
  input  wire logic [31:0]          raddr_i,
  input  wire logic [2:0]           wst_i,
  input  wire logic [4:0]           wcnt_i,
  input  wire logic [15:0]          wbm_i,
  input  wire logic                 wbaddr_en_i,
  output dcc_pkg::dp_stat_t         stat_o
);
  logic [2:0]  st_mem [dcc_pkg::BLOCKS];
  logic [4:0]  cnt_mem [dcc_pkg::BLOCKS];
  logic [15:0] bm_mem [dcc_pkg::BLOCKS];
  logic [31:0] ba_mem [dcc_pkg::BLOCKS];
  logic [31:0] la_mem [dcc_pkg::BLOCKS*dcc_pkg::NODES];
  logic [13:0] la_idx;
  logic [2:0]  st_q;
  logic [4:0]  cnt_q;
  logic [15:0] bm_q;
  logic [31:0] baddr_q;
  logic [31:0] laddr_q;

  assign la_idx = cmd_i.wr_line ? {blk_i, req_i} : {blk_i, cmd_i.rd_node};
  assign stat_o = '{st: st_q, cnt: cnt_q, bm: bm_q, baddr: baddr_q, laddr: laddr_q};

  // Entry memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      st_mem[blk_i] <= wst_i;
      cnt_mem[blk_i] <= wcnt_i;
      bm_mem[blk_i] <= wbm_i;
      if (wbaddr_en_i) begin
        ba_mem[blk_i] <= baddr_i;
      end
    end
    if (cmd_i.rd_entry) begin
      st_q <= st_mem[blk_i];
      cnt_q <= cnt_mem[blk_i];
      bm_q <= bm_mem[blk_i];
      baddr_q <= ba_mem[blk_i];
    end
  end

  // Line address memory, one port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_line) begin
      la_mem[la_idx] <= raddr_i;
    end else if (cmd_i.rd_line) begin
      laddr_q <= la_mem[la_idx];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dcc_controller.sv =====
// Directory controller state machine: decides each message, drives the
// datapath and sequences result transfers. Depends on dcc_pkg and the macros.
`default_nettype none
`include "directory_coherence_controller_macros.svh"
module dcc_controller (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire dcc_pkg::in_item_t    in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output dcc_pkg::out_item_t        out_data_o,
  output dcc_pkg::dp_cmd_t          cmd_o,
  output logic [9:0]                blk_o,
  output logic [3:0]                req_o,
  output logic [31:0]               raddr_o,
  output logic [2:0]                wst_o,
  output logic [4:0]                wcnt_o,
  output logic [15:0]               wbm_o,
  output logic                      wbaddr_en_o,
  input  wire dcc_pkg::dp_stat_t    stat_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_OWNER, S_SEND, S_FAN_RD, S_FAN_SEND
  } state_e;

  state_e            state_q;
  dcc_pkg::in_item_t it_q;
  logic [15:0]       fan_q;      // remaining fan-out targets
  logic [3:0]        fan_type_q;
  logic [3:0]        node_q;
  logic              more_q;     // fan-out follows the pending reply

  logic [15:0] bm;
  logic        hreq;
  logic [3:0]  own;
  logic [15:0] req_oh, ag_oh;
  logic [4:0]  cinc, cdec;
  logic        emit, fan, owner_msg, wline;
  logic [3:0]  rtype;
  logic [2:0]  ns;
  logic [4:0]  nc;
  logic [15:0] nbm, fan_bm;
  logic [3:0]  top_fan;

  // Decision logic on the freshly read entry.
  always_comb begin
    bm = stat_i.bm;
    req_oh = 16'(1) << it_q.requester_node;
    ag_oh = 16'(1) << it_q.agent_node;
    hreq = bm[it_q.requester_node];
    own = '0;
    for (int i = 0; i < dcc_pkg::NODES; i++) begin
      if (bm[i]) own = 4'(i);
    end
    cinc = (stat_i.cnt >= 5'(dcc_pkg::NODES)) ? 5'(dcc_pkg::NODES) : stat_i.cnt + 5'd1;
    cdec = (stat_i.cnt == 5'd0) ? 5'd0 : stat_i.cnt - 5'd1;
    emit = 1'b0; fan = 1'b0; owner_msg = 1'b0; wline = 1'b0;
    rtype = dcc_pkg::RP_ST_FAIL;
    ns = stat_i.st; nc = stat_i.cnt; nbm = bm; fan_bm = bm;
    case (it_q.msg_type)
      dcc_pkg::MT_RD_MISS: begin
        emit = 1'b1;
        if ((stat_i.st == dcc_pkg::ST_UN) || (stat_i.st == dcc_pkg::ST_SH)) begin
          if (hreq) rtype = dcc_pkg::RP_BM_FAIL;
          else begin
            ns = dcc_pkg::ST_SH; nc = cinc; nbm = bm | req_oh; wline = 1'b1;
            rtype = dcc_pkg::RP_RD_ACK;
          end
        end else if (stat_i.st == dcc_pkg::ST_DI) begin
          if (hreq) rtype = dcc_pkg::RP_BM_FAIL;
          else begin
            ns = dcc_pkg::ST_TOSH; wline = 1'b1; owner_msg = 1'b1;
            rtype = dcc_pkg::RP_AG_RMD;
          end
        end
      end
      dcc_pkg::MT_WR_MISS: begin
        emit = 1'b1;
        if (stat_i.st == dcc_pkg::ST_UN) begin
          if (hreq) rtype = dcc_pkg::RP_BM_FAIL;
          else begin
            ns = dcc_pkg::ST_DI; nc = 5'd1; nbm = bm | req_oh; wline = 1'b1;
            rtype = dcc_pkg::RP_WR_ACK;
          end
        end else if (stat_i.st == dcc_pkg::ST_SH) begin
          if (hreq) rtype = dcc_pkg::RP_BM_FAIL;
          else begin
            ns = dcc_pkg::ST_TODI; wline = 1'b1; fan = 1'b1;
            rtype = dcc_pkg::RP_WR_SHDATA;
          end
        end else if (stat_i.st == dcc_pkg::ST_DI) begin
          if (hreq) rtype = dcc_pkg::RP_BM_FAIL;
          else begin
            ns = dcc_pkg::ST_TODI; wline = 1'b1; owner_msg = 1'b1;
            rtype = dcc_pkg::RP_AG_WMD;
          end
        end
      end
      dcc_pkg::MT_WR_SHARED: begin
        if (stat_i.st != dcc_pkg::ST_SH) emit = 1'b1;
        else if (!hreq) begin
          emit = 1'b1; rtype = dcc_pkg::RP_BM_FAIL;
        end else if (stat_i.cnt > 5'd1) begin
          ns = dcc_pkg::ST_TODI; fan = 1'b1; fan_bm = bm & ~req_oh;
        end else begin
          emit = 1'b1; ns = dcc_pkg::ST_DI; nc = 5'd1; nbm = bm | req_oh;
          rtype = dcc_pkg::RP_WS_ONLY;
        end
      end
      dcc_pkg::MT_EVICT_SH: begin
        emit = 1'b1;
        if (stat_i.st == dcc_pkg::ST_SH) begin
          if (!hreq) rtype = dcc_pkg::RP_BM_FAIL;
          else begin
            ns = (stat_i.cnt == 5'd1) ? dcc_pkg::ST_UN : dcc_pkg::ST_SH;
            nbm = bm & ~req_oh; nc = cdec; rtype = dcc_pkg::RP_EV_SH;
          end
        end
      end
      dcc_pkg::MT_EVICT_DI: begin
        emit = 1'b1;
        if (stat_i.st == dcc_pkg::ST_DI) begin
          if (!hreq) rtype = dcc_pkg::RP_BM_FAIL;
          else begin
            ns = dcc_pkg::ST_UN; nbm = bm & ~req_oh; nc = cdec;
            rtype = dcc_pkg::RP_EV_DI;
          end
        end
      end
      dcc_pkg::MT_ACK_RMD: begin
        if (stat_i.st == dcc_pkg::ST_TOSH) begin
          ns = dcc_pkg::ST_SH; nbm = bm | req_oh; nc = cinc;
        end
      end
      dcc_pkg::MT_ACK_WMD: begin
        if (stat_i.st == dcc_pkg::ST_TODI) begin
          ns = dcc_pkg::ST_DI; nbm = (bm | req_oh) & ~ag_oh; nc = 5'd1;
        end
      end
      dcc_pkg::MT_ACK_WMS: begin
        if (stat_i.st == dcc_pkg::ST_TODI) begin
          nbm = (bm | req_oh) & ~ag_oh;
          if (stat_i.cnt == 5'd1) begin
            ns = dcc_pkg::ST_DI; emit = 1'b1; rtype = dcc_pkg::RP_WMS_AGG;
          end else nc = cdec;
        end
      end
      dcc_pkg::MT_ACK_WSN: begin
        if (stat_i.st == dcc_pkg::ST_TODI) begin
          nbm = (bm | req_oh) & ~ag_oh;
          if (stat_i.cnt == 5'd2) begin
            ns = dcc_pkg::ST_DI; nc = 5'd1; emit = 1'b1; rtype = dcc_pkg::RP_WSN_AGG;
          end else nc = cdec;
        end
      end
      default: begin
      end
    endcase
  end

  // Highest remaining fan-out target.
  always_comb begin
    top_fan = '0;
    for (int i = 0; i < dcc_pkg::NODES; i++) begin
      if (fan_q[i]) top_fan = 4'(i);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign blk_o = it_q.block_index;
  assign req_o = it_q.requester_node;
  assign raddr_o = it_q.requester_line_address;
  assign wbaddr_en_o = (state_q == S_IDLE);

  // Datapath commands and write data. An owner request reads the owner line
  // address in the decide state and writes the requester line address in the owner state.
  always_comb begin
    cmd_o = '0;
    wst_o = ns; wcnt_o = nc; wbm_o = nbm;
    case (state_q)
      S_IDLE: begin
        wst_o = dcc_pkg::ST_UN; wcnt_o = '0; wbm_o = '0;
      end
      S_DECIDE: begin
        cmd_o.wr_entry = 1'b1;
        cmd_o.wr_line = wline && !owner_msg;
        cmd_o.rd_line = owner_msg;
        cmd_o.rd_node = own;
      end
      S_OWNER: begin
        cmd_o.wr_line = 1'b1;
      end
      S_FAN_RD: begin
        cmd_o.rd_line = 1'b1;
        cmd_o.rd_node = top_fan;
      end
      default: begin
      end
    endcase
  end

  // Main sequencer with registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_o <= 1'b0;
      out_data_o <= '0;
      it_q <= '0;
      fan_q <= '0;
      fan_type_q <= '0;
      node_q <= '0;
      more_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            it_q <= in_data_i;
            state_q <= S_IDLE;
          end
          if (in_valid_i && in_data_i.kind) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          fan_type_q <= (it_q.msg_type == dcc_pkg::MT_WR_SHARED) ?
                        dcc_pkg::RP_AG_WSN : dcc_pkg::RP_AG_WMS;
          fan_q <= fan ? fan_bm : '0;
          more_q <= fan && (fan_bm != '0);
          out_data_o.reply_type <= rtype;
          out_data_o.dest_node <= owner_msg ? own : it_q.requester_node;
          out_data_o.owner_node <= owner_msg ? own : 4'd0;
          out_data_o.owner_line_address <= '0;
          out_data_o.out_block_address <= stat_i.baddr;
          out_data_o.out_requester_node <= it_q.requester_node;
          out_data_o.out_requester_address <= it_q.requester_line_address;
          out_data_o.sharers <= bm;
          out_data_o.last <= !(fan && (fan_bm != '0));
          if (owner_msg) state_q <= S_OWNER;
          else if (emit) begin
            out_valid_o <= 1'b1;
            state_q <= S_SEND;
          end else if (fan && (fan_bm != '0)) state_q <= S_FAN_RD;
          else state_q <= S_IDLE;
          node_q <= own;
        end
        S_OWNER: begin
          out_data_o.owner_line_address <= stat_i.laddr;
          out_valid_o <= 1'b1;
          state_q <= S_SEND;
        end
        S_SEND: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= more_q ? S_FAN_RD : S_IDLE;
          end
          if (more_q) node_q <= top_fan;
        end
        S_FAN_RD: begin
          node_q <= top_fan;
          fan_q[top_fan] <= 1'b0;
          state_q <= S_FAN_SEND;
          out_valid_o <= 1'b0;
        end
        S_FAN_SEND: begin
          if (!out_valid_o) begin
            out_data_o.reply_type <= fan_type_q;
            out_data_o.dest_node <= node_q;
            out_data_o.owner_node <= node_q;
            out_data_o.owner_line_address <= stat_i.laddr;
            out_data_o.last <= (fan_q == '0);
            out_valid_o <= 1'b1;
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= (fan_q == '0) ? S_IDLE : S_FAN_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `DCC_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, out_valid_o, !in_ready_o, "ready during result")
  `DCC_ASSERT_NEXT(a_fan_shrinks, clk_i, rst_ni, state_q == S_FAN_RD, fan_q != $past(fan_q) || fan_q == '0, "fan set did not shrink")
  `DCC_ASSERT_IMPL(a_last_fan, clk_i, rst_ni, out_valid_o && state_q == S_FAN_SEND && out_data_o.last, fan_q == '0, "last with targets left")
endmodule
`default_nettype wire

// ===== rtl/directory_coherence_controller.sv =====
// Directory coherence controller top level: controller plus directory
// datapath. Depends on dcc_pkg, dcc_controller, dcc_datapath and the macros.
//
// Usage: items enter on in_valid_i/in_ready_o with payload in_data_i; results
// leave on out_valid_o/out_ready_i with payload out_data_o. An init item
// (kind 0) writes its entry in the accept cycle and produces no result; the
// block is ready again the next cycle. A coherence message reads its entry
// in the accept cycle, decides and writes back in the decide state and
// then offers a plain reply from the send state. A dirty-owner request
// first passes the owner state to load the owner line address. Invalidation
// fan-out handles each sharer in turn: it reads its line address on the single
// memory port, loads the result register and offers it, ending with last set.
// Only one item is in flight at a time, so the input stays not ready until
// the final result transfer. A stalled receiver holds the result register
// and the whole block. Reset returns the sequencer to idle with no result
// pending; directory contents are undefined until init items write them.
`default_nettype none
`include "directory_coherence_controller_macros.svh"
module directory_coherence_controller (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire dcc_pkg::in_item_t    in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output dcc_pkg::out_item_t        out_data_o
);
  dcc_pkg::dp_cmd_t  cmd;
  dcc_pkg::dp_stat_t stat;
  dcc_pkg::dp_cmd_t  cmd_dp;
  logic [9:0]  blk_ctl, blk;
  logic [3:0]  req_ctl;
  logic [31:0] raddr_ctl;
  logic [2:0]  wst;
  logic [4:0]  wcnt;
  logic [15:0] wbm;
  logic        wbaddr_en;
  logic        take;

  // In the accept cycle the datapath works on the incoming item directly.
  assign take = in_valid_i && in_ready_o;
  assign blk = take ? in_data_i.block_index : blk_ctl;
  always_comb begin
    cmd_dp = cmd;
    if (take) begin
      cmd_dp.rd_entry = in_data_i.kind;
      cmd_dp.wr_entry = !in_data_i.kind;
    end
  end

  dcc_controller u_ctl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cmd_o(cmd), .blk_o(blk_ctl), .req_o(req_ctl), .raddr_o(raddr_ctl),
    .wst_o(wst), .wcnt_o(wcnt), .wbm_o(wbm),
    .wbaddr_en_o(wbaddr_en), .stat_i(stat)
  );

  dcc_datapath u_dp (
    .clk_i, .cmd_i(cmd_dp), .blk_i(blk), .baddr_i(in_data_i.block_address),
    .req_i(req_ctl), .raddr_i(raddr_ctl),
    .wst_i(wst), .wcnt_i(wcnt), .wbm_i(wbm), .wbaddr_en_i(wbaddr_en && take),
    .stat_o(stat)
  );

  `DCC_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, out_valid_o, !take, "accept while result pending")
  `DCC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped")
endmodule
`default_nettype wire
